@@ rtl/core/seen_device_throttle_cache_core_assert.svh @@
// assertion macros for the seen device throttle cache core
// expects clk_i and rst_ni in the scope of each use
`ifndef SEEN_DEVICE_THROTTLE_CACHE_CORE_ASSERT_SVH
`define SEEN_DEVICE_THROTTLE_CACHE_CORE_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define SDTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SDTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/sdtc_pkg.sv @@
// shared types and constants for the seen device throttle cache core
// no dependencies
package sdtc_pkg;

  localparam int unsigned ENTRIES_DEF    = 32;
  localparam int unsigned ADDR_W         = 48;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned RSSI_W         = 8;
  localparam int unsigned SLOT_W         = 5;
  localparam int unsigned CNT_W          = 32;
  localparam int unsigned IN_DATA_W      = 88;
  localparam int unsigned OUT_DATA_W     = 96;
  localparam int unsigned OUT_USER_W     = 2;
  localparam int unsigned APB_ADDR_W     = 3;
  localparam int unsigned APB_DATA_W     = 32;
  localparam logic [TIME_W-1:0] THROTTLE_RESET = 32'd5000;
  localparam logic [0:0] REG_THROTTLE    = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last_rd;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/core/sdtc_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module sdtc_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sdtc_ctrl.sv @@
// controller state machine: accept, table scan, decision and hand-off
// depends on sdtc_pkg and seen_device_throttle_cache_core_assert.svh
`include "seen_device_throttle_cache_core_assert.svh"

module sdtc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  sdtc_pkg::sts_t sts_i,
  output sdtc_pkg::cmd_t cmd_o
);
  import sdtc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.last_rd) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DECIDE: begin
        cmd_o.commit = !sts_i.out_busy;
      end
      default: begin
      end
    endcase
  end

  `SDTC_ASSERT_NEXT(a_accept_scan, state_q == ST_IDLE && s_tvalid_i, state_q == ST_SCAN,
                    "accepted transaction did not start a scan")
  `SDTC_ASSERT_NEXT(a_last_drain, state_q == ST_SCAN && sts_i.last_rd, state_q == ST_DRAIN,
                    "scan did not end after the last entry")
  `SDTC_ASSERT(a_commit_free, cmd_o.commit |-> !sts_i.out_busy,
               "result committed while output register still held")
  `SDTC_ASSERT_NEXT(a_commit_idle, cmd_o.commit, state_q == ST_IDLE,
                    "controller did not return to idle after commit")

endmodule

@@ rtl/core/sdtc_dpath.sv @@
// datapath: input capture, table ram, scan compare, decision and output register
// depends on sdtc_pkg and sdtc_ram
module sdtc_dpath #(
  parameter int unsigned ENTRIES = sdtc_pkg::ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sdtc_pkg::cmd_t                      cmd_i,
  output sdtc_pkg::sts_t                      sts_o,
  input  logic [sdtc_pkg::IN_DATA_W-1:0]      s_tdata_i,
  input  logic [sdtc_pkg::TIME_W-1:0]         throttle_i,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [sdtc_pkg::OUT_DATA_W-1:0]     m_tdata_o,
  output logic [sdtc_pkg::OUT_USER_W-1:0]     m_tuser_o
);
  import sdtc_pkg::*;

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned WORD_W = ADDR_W + TIME_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [ADDR_W-1:0] addr_q;
  logic [TIME_W-1:0] time_q;
  logic [RSSI_W-1:0] rssi_q;

  logic [IDX_W-1:0]  rd_idx_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              cmp_vld_q;

  logic              have_free_q;
  logic [IDX_W-1:0]  free_slot_q;
  logic              matched_q;
  logic [IDX_W-1:0]  match_slot_q;
  logic [TIME_W-1:0] match_time_q;
  logic              have_old_q;
  logic [IDX_W-1:0]  old_slot_q;
  logic [TIME_W-1:0] old_time_q;

  logic [ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]   count_q;

  logic                  out_vld_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  logic [WORD_W-1:0] rdata;
  logic [ADDR_W-1:0] ent_addr;
  logic [TIME_W-1:0] ent_time;
  logic              ent_vld;
  logic [IDX_W-1:0]  slot_sel;
  logic [TIME_W-1:0] delta;
  logic              emit;
  logic              wr_en;
  logic [CNT_W-1:0]  count_nxt;

  assign ent_addr = rdata[ADDR_W-1:0];
  assign ent_time = rdata[WORD_W-1:ADDR_W];
  assign ent_vld  = valid_q[cmp_idx_q];

  assign delta     = time_q - match_time_q;
  assign emit      = !matched_q || (delta >= throttle_i);
  assign slot_sel  = matched_q ? match_slot_q : (have_free_q ? free_slot_q : old_slot_q);
  assign wr_en     = cmd_i.commit && emit;
  assign count_nxt = matched_q ? count_q : count_q + CNT_W'(1);

  sdtc_ram #(
    .WIDTH(WORD_W),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (slot_sel),
    .wdata_i ({time_q, addr_q}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= s_tdata_i[ADDR_W-1:0];
      time_q <= s_tdata_i[ADDR_W+TIME_W-1:ADDR_W];
      rssi_q <= s_tdata_i[ADDR_W+TIME_W+RSSI_W-1:ADDR_W+TIME_W];
    end
    if (cmd_i.rd_en) begin
      cmp_idx_q <= rd_idx_q;
    end
    if (cmd_i.commit) begin
      out_data_q <= {3'b000, count_nxt, rssi_q, addr_q, SLOT_W'(slot_sel)};
      out_user_q <= {!matched_q, emit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q     <= '0;
      cmp_vld_q    <= 1'b0;
      have_free_q  <= 1'b0;
      free_slot_q  <= '0;
      matched_q    <= 1'b0;
      match_slot_q <= '0;
      match_time_q <= '0;
      have_old_q   <= 1'b0;
      old_slot_q   <= '0;
      old_time_q   <= '0;
      valid_q      <= '0;
      count_q      <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.rd_en;
      if (cmd_i.load) begin
        rd_idx_q    <= '0;
        have_free_q <= 1'b0;
        matched_q   <= 1'b0;
        have_old_q  <= 1'b0;
      end else if (cmd_i.rd_en) begin
        rd_idx_q <= rd_idx_q + IDX_W'(1);
      end
      if (cmp_vld_q) begin
        if (!ent_vld) begin
          have_free_q <= 1'b1;
          free_slot_q <= cmp_idx_q;
        end else if (ent_addr == addr_q) begin
          matched_q    <= 1'b1;
          match_slot_q <= cmp_idx_q;
          match_time_q <= ent_time;
        end else if (!have_old_q || ent_time < old_time_q) begin
          have_old_q <= 1'b1;
          old_slot_q <= cmp_idx_q;
          old_time_q <= ent_time;
        end
      end
      if (cmd_i.commit) begin
        count_q <= count_nxt;
        if (!matched_q) begin
          valid_q[slot_sel] <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.last_rd  = cmd_i.rd_en && (rd_idx_q == LAST_IDX);
  assign sts_o.out_busy = out_vld_q && !m_tready_i;

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

endmodule

@@ rtl/core/seen_device_throttle_cache_core.sv @@
// Seen device throttle cache. Each accepted report scans the whole device table
// one entry per cycle through the single read port of the table ram; the last
// entry is compared in the drain state and the decide state commits the result
// to the output register. The next report is accepted the cycle after that
// commit while the result waits to be taken, so no report is taken while the
// previous one is in progress. A result untaken when the next one is decided
// holds that decision until it leaves. A known device is passed for logging
// only once the wrapping time since its last logged report reaches the throttle
// interval; an unknown one takes the highest free slot, or else replaces the
// entry with the oldest report time. Reset clears the table at once.
module seen_device_throttle_cache_core #(
  parameter int unsigned ENTRIES = sdtc_pkg::ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // device_address [47:0], timestamp_ms [79:48], signal_strength [87:80]
  input  logic [sdtc_pkg::IN_DATA_W-1:0]      s_tdata_i,
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  // slot_index [4:0], address_echo [52:5], strength_echo [60:53],
  // devices_seen [92:61], zero fill [95:93]
  output logic [sdtc_pkg::OUT_DATA_W-1:0]     m_tdata_o,
  // emit_log [0], is_new_device [1]
  output logic [sdtc_pkg::OUT_USER_W-1:0]     m_tuser_o,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [sdtc_pkg::APB_ADDR_W-1:0]     paddr_i,
  input  logic [sdtc_pkg::APB_DATA_W-1:0]     pwdata_i,
  output logic [sdtc_pkg::APB_DATA_W-1:0]     prdata_o,
  output logic                                pready_o
);
  import sdtc_pkg::*;

  logic [TIME_W-1:0] throttle_q;
  logic              reg_sel;
  cmd_t              cmd;
  sts_t              sts;

  assign pready_o = 1'b1;
  assign reg_sel  = (paddr_i[2] == REG_THROTTLE);
  assign prdata_o = reg_sel ? throttle_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      throttle_q <= THROTTLE_RESET;
    end else if (psel_i && penable_i && pwrite_i && pready_o && reg_sel) begin
      throttle_q <= pwdata_i;
    end
  end

  sdtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sdtc_dpath #(
    .ENTRIES(ENTRIES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_tdata_i),
    .throttle_i (throttle_q),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

endmodule
